// ===== sv/pmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared widths, register indexes and stage types of the PID motor drive.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int DATA_W   = 16;   // every register and input field
    localparam int ERR_W    = 17;   // target - measured
    localparam int SUM_W    = 32;   // saturating error sum
    localparam int PDIFF_W  = 19;   // 3*target - 4*measured
    localparam int DDIFF_W  = 17;   // speed - previous speed
    localparam int PPROD_W  = DATA_W + PDIFF_W;
    localparam int IPROD_W  = DATA_W + SUM_W;
    localparam int DPROD_W  = DATA_W + DDIFF_W;
    localparam int U_W      = 52;   // Q.10 loop sum
    localparam int FRAC_W   = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KP            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_TIMES_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_OVER_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DRIVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_STEPS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OUTPUT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTPUT    = 3'd6;

    typedef struct packed {
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] ki_times_step;
        logic signed [DATA_W-1:0] kd_over_step;
        logic signed [DATA_W-1:0] initial_drive;
        logic        [DATA_W-1:0] guard_steps;
        logic signed [DATA_W-1:0] min_output;
        logic signed [DATA_W-1:0] max_output;
    } cfg_t;

    // prep -> multiply
    typedef struct packed {
        logic                      startup;
        logic                      floor_en;
        logic signed [ERR_W-1:0]   err;
        logic signed [PDIFF_W-1:0] p_diff;
        logic signed [SUM_W-1:0]   err_sum;
        logic signed [DDIFF_W-1:0] d_diff;
    } prep_t;

    // multiply -> post
    typedef struct packed {
        logic                      startup;
        logic                      floor_en;
        logic signed [ERR_W-1:0]   err;
        logic signed [PPROD_W-1:0] p_prod;
        logic signed [IPROD_W-1:0] i_prod;
        logic signed [DPROD_W-1:0] d_prod;
    } prod_t;

endpackage

// ===== sv/pmd_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_prep
// Start-up decision, tick counter, error sum and difference terms.
// ----------------------------------------------------------------------------
module pmd_prep
    import pmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic signed [DATA_W-1:0] target,
    input  logic signed [DATA_W-1:0] measured,
    input  logic signed [DATA_W-1:0] encoder_speed,
    input  cfg_t                     cfg,
    output prep_t                    stage_reg,
    output logic [DATA_W-1:0]        tick_count
);

    logic        [DATA_W-1:0] tick_reg;
    logic signed [SUM_W-1:0]  err_sum_reg;
    logic signed [DATA_W-1:0] prev_speed_reg;

    logic                      first_tick;
    logic                      hold_tick;
    logic                      run_loop;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   err_sum_next;
    logic signed [PDIFF_W-1:0] t_ext;
    logic signed [PDIFF_W-1:0] m_ext;
    prep_t                     stage_next;

    always_comb
    begin
        first_tick = (tick_reg == '0);
        hold_tick  = (tick_reg == DATA_W'(1)) && (encoder_speed < 16'sd2);
        run_loop   = !first_tick && !hold_tick;

        err      = ERR_W'(target) - ERR_W'(measured);
        sum_wide = (SUM_W+1)'(err) + (SUM_W+1)'(err_sum_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            err_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
        else
            err_sum_next = sum_wide[SUM_W-1:0];

        t_ext = PDIFF_W'(target);
        m_ext = PDIFF_W'(measured);

        stage_next.startup  = !run_loop;
        stage_next.floor_en = (tick_reg < cfg.guard_steps);
        stage_next.err      = err;
        stage_next.p_diff   = (t_ext <<< 1) + t_ext - (m_ext <<< 2);
        stage_next.err_sum  = err_sum_next;
        stage_next.d_diff   = DDIFF_W'(encoder_speed) - DDIFF_W'(prev_speed_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            err_sum_reg    <= '0;
            prev_speed_reg <= '0;
        end
        else if (load)
        begin
            if (first_tick)
                tick_reg <= DATA_W'(1);
            else if (run_loop)
            begin
                err_sum_reg    <= err_sum_next;
                prev_speed_reg <= encoder_speed;
                if (tick_reg != {DATA_W{1'b1}})
                    tick_reg <= tick_reg + DATA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            stage_reg <= stage_next;
    end

    assign tick_count = tick_reg;

endmodule

// ===== sv/pmd_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_mult
// The three gain products, registered.
// ----------------------------------------------------------------------------
module pmd_mult
    import pmd_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  prep_t prep,
    input  cfg_t  cfg,
    output prod_t stage_reg
);

    prod_t stage_next;

    always_comb
    begin
        stage_next.startup  = prep.startup;
        stage_next.floor_en = prep.floor_en;
        stage_next.err      = prep.err;
        stage_next.p_prod   = PPROD_W'($signed(cfg.kp)) * PPROD_W'($signed(prep.p_diff));
        stage_next.i_prod   = IPROD_W'($signed(cfg.ki_times_step))
                            * IPROD_W'($signed(prep.err_sum));
        stage_next.d_prod   = DPROD_W'($signed(cfg.kd_over_step))
                            * DPROD_W'($signed(prep.d_diff));
    end

    always_ff @(posedge clk)
    begin
        if (load)
            stage_reg <= stage_next;
    end

endmodule

// ===== sv/pmd_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_post
// Q.10 sum, guard floor, clamp, rounding and the held loop values.
// ----------------------------------------------------------------------------
module pmd_post
    import pmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load_sum,
    input  logic                     load_out,
    input  prod_t                    prod,
    input  cfg_t                     cfg,
    output logic signed [DATA_W-1:0] drive_reg,
    output logic signed [DATA_W-1:0] raw_reg,
    output logic signed [ERR_W-1:0]  err_reg,
    output logic                     startup_reg
);

    localparam int RND_W = U_W - FRAC_W;

    // half away from zero
    function automatic logic signed [RND_W-1:0] round_q10(input logic signed [U_W-1:0] v);
        logic signed [U_W-1:0] t;
        begin
            t = v + (v[U_W-1] ? U_W'(511) : U_W'(512));
            return t[U_W-1:FRAC_W];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [RND_W-1:0] v);
        begin
            if (v > RND_W'(32767))
                return 16'sh7FFF;
            else if (v < -RND_W'(32768))
                return 16'sh8000;
            else
                return v[DATA_W-1:0];
        end
    endfunction

    logic                    startup3_reg;
    logic                    floor3_reg;
    logic signed [ERR_W-1:0] err3_reg;
    logic signed [U_W-1:0]   u3_reg;
    logic signed [U_W-1:0]   u_next;

    logic signed [DATA_W-1:0] held_raw_reg;
    logic signed [ERR_W-1:0]  held_err_reg;

    logic signed [U_W-1:0]    init_q;
    logic signed [U_W-1:0]    hi_q;
    logic signed [U_W-1:0]    lo_q;
    logic signed [U_W-1:0]    u_floor;
    logic signed [RND_W-1:0]  u_rnd;
    logic signed [DATA_W-1:0] raw_next;
    logic signed [DATA_W-1:0] drive_loop;

    always_comb
    begin
        u_next = U_W'($signed(prod.p_prod))
               + (U_W'($signed(prod.i_prod)) <<< 2)
               + (U_W'($signed(prod.d_prod)) <<< 2);
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            startup3_reg <= prod.startup;
            floor3_reg   <= prod.floor_en;
            err3_reg     <= prod.err;
            u3_reg       <= u_next;
        end
    end

    always_comb
    begin
        init_q  = U_W'($signed(cfg.initial_drive)) <<< FRAC_W;
        hi_q    = U_W'($signed(cfg.max_output)) <<< FRAC_W;
        lo_q    = U_W'($signed(cfg.min_output)) <<< FRAC_W;
        u_floor = (floor3_reg && (u3_reg < init_q)) ? init_q : u3_reg;
        u_rnd   = round_q10(u_floor);
        raw_next = sat16(u_rnd);
        // inverted range: above max wins
        if (u_floor > hi_q)
            drive_loop = cfg.max_output;
        else if (u_floor < lo_q)
            drive_loop = cfg.min_output;
        else
            drive_loop = u_rnd[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_raw_reg <= '0;
            held_err_reg <= '0;
        end
        else if (load_out && !startup3_reg)
        begin
            held_raw_reg <= raw_next;
            held_err_reg <= err3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            startup_reg <= startup3_reg;
            if (startup3_reg)
            begin
                drive_reg <= cfg.initial_drive;
                raw_reg   <= held_raw_reg;
                err_reg   <= held_err_reg;
            end
            else
            begin
                drive_reg <= drive_loop;
                raw_reg   <= raw_next;
                err_reg   <= err3_reg;
            end
        end
    end

endmodule

// ===== sv/pid_motor_drive_with_startup.sv =====
`timescale 1ns / 1ps
// The input register loads at the accepting edge, then the prep, multiply, sum and
// output registers follow. Throughput: one word per cycle while m_tready stays high;
// each register stage moves on when the next is free.
// Reset clears configuration to defaults, tick counter, error sum, previous speed
// and the held loop values; all stages come up empty.
// ----------------------------------------------------------------------------
// pid_motor_drive_with_startup
// PID drive with start-up hold, guard floor, clamp and rounding, one tick per word.
// ----------------------------------------------------------------------------
module pid_motor_drive_with_startup
    import pmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // target, measured, encoder_speed

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // drive, raw_drive, loop_error, zero pad
    output logic                 m_tuser    // in_startup
);

    cfg_t cfg_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg, vout_reg;
    logic en0, en1, en2, en3, en_out;

    logic signed [DATA_W-1:0] target_reg;
    logic signed [DATA_W-1:0] measured_reg;
    logic signed [DATA_W-1:0] speed_reg;

    prep_t                    prep_stage;
    prod_t                    prod_stage;
    logic [DATA_W-1:0]        tick_count;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] raw_drive;
    logic signed [ERR_W-1:0]  loop_error;
    logic                     in_startup;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp            <= '0;
            cfg_reg.ki_times_step <= '0;
            cfg_reg.kd_over_step  <= '0;
            cfg_reg.initial_drive <= '0;
            cfg_reg.guard_steps   <= '0;
            cfg_reg.min_output    <= 16'sh8000;
            cfg_reg.max_output    <= 16'sh7FFF;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_KP:            cfg_reg.kp            <= cfg_data;
                CFG_KI_TIMES_STEP: cfg_reg.ki_times_step <= cfg_data;
                CFG_KD_OVER_STEP:  cfg_reg.kd_over_step  <= cfg_data;
                CFG_INITIAL_DRIVE: cfg_reg.initial_drive <= cfg_data;
                CFG_GUARD_STEPS:   cfg_reg.guard_steps   <= cfg_data;
                CFG_MIN_OUTPUT:    cfg_reg.min_output    <= cfg_data;
                CFG_MAX_OUTPUT:    cfg_reg.max_output    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // a stage loads when it is empty or its word moves on
    assign en_out   = !vout_reg || m_tready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (en0)    v0_reg   <= s_tvalid;
            if (en1)    v1_reg   <= v0_reg;
            if (en2)    v2_reg   <= v1_reg;
            if (en3)    v3_reg   <= v2_reg;
            if (en_out) vout_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && s_tvalid)
        begin
            target_reg   <= s_tdata[15:0];
            measured_reg <= s_tdata[31:16];
            speed_reg    <= s_tdata[47:32];
        end
    end

    pmd_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (en1 && v0_reg),
        .target        (target_reg),
        .measured      (measured_reg),
        .encoder_speed (speed_reg),
        .cfg           (cfg_reg),
        .stage_reg     (prep_stage),
        .tick_count    (tick_count)
    );

    pmd_mult u_mult (
        .clk       (clk),
        .load      (en2 && v1_reg),
        .prep      (prep_stage),
        .cfg       (cfg_reg),
        .stage_reg (prod_stage)
    );

    pmd_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_sum    (en3 && v2_reg),
        .load_out    (en_out && v3_reg),
        .prod        (prod_stage),
        .cfg         (cfg_reg),
        .drive_reg   (drive),
        .raw_reg     (raw_drive),
        .err_reg     (loop_error),
        .startup_reg (in_startup)
    );

    assign m_tvalid = vout_reg;
    assign m_tdata  = {7'd0, loop_error, raw_drive, drive};
    assign m_tuser  = in_startup;

`ifndef SYNTHESIS
    // empty pipe must take a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !(v0_reg || v1_reg || v2_reg || v3_reg || vout_reg) |-> s_tready)
        else $error("pipe empty but input not ready");

    // counter never returns to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_count != '0) |=> (tick_count != '0))
        else $error("tick counter went back to zero");

    // newest state update was a start-up tick, so the counter sits at one
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && prep_stage.startup) |-> (tick_count == DATA_W'(1)))
        else $error("start-up word with tick counter not at one");
`endif

endmodule

// ===== verif/pid_motor_drive_with_startup_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_drive_with_startup_test
// Self-checking bench for the PID motor drive. A directed table walks the
// start-up ticks, the gain and input extremes, rounding, the inverted output
// range and the guard floor. Random register settings and random ticks follow.
// Every drive word is checked field by field against a local predictor or a
// table word, with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module pid_motor_drive_with_startup_test;
    import pmd_pkg::*;

    localparam int LATENCY        = 5;
    localparam int IDLE_PCT       = 19;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 11;
    localparam int RANDOM_TICKS   = 1650;
    localparam int SHOW_LIMIT     = 40;
    localparam int HOLD_OFF       = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // no register behind it
    localparam longint ACC_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint ACC_MIN = -(longint'(1) <<< (SUM_W - 1));
    localparam longint HALF_LSB = longint'(1) <<< (FRAC_W - 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] raw;
        logic signed [ERR_W-1:0]  err;
        logic                     startup;
    } drive_word_t;

    typedef struct {
        bit                       is_write;
        logic [CFG_IDX_W-1:0]     idx;
        logic [DATA_W-1:0]        val;
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] spd;
        bit                       typed;
        drive_word_t              want;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;   // target, measured, encoder_speed
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;          // drive, raw_drive, loop_error, zero pad
    logic                 m_tuser;          // in_startup

    pid_motor_drive_with_startup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor copy of the registers and loop state
    logic signed [DATA_W-1:0] gain_p, gain_i, gain_d, start_drive, out_lo, out_hi;
    logic [DATA_W-1:0]        guard_ticks, tick_ctr;
    logic signed [SUM_W-1:0]  integ_acc;
    logic signed [DATA_W-1:0] last_speed, hold_raw;
    logic signed [ERR_W-1:0]  hold_err;

    drive_word_t pending_drive[$];
    stim_row_t   directed_rows[$];

    bit calm      = 1'b0;
    int stall_req = 0;
    int mismatches, words_seen, ticks_sent, reg_writes, quiet;
    bit ctr_held, acc_hit_hi, acc_hit_lo;

    function automatic longint round_half_away(input longint v);
        if (v >= 0)
            return (v + HALF_LSB) >>> FRAC_W;
        return -((-v + HALF_LSB) >>> FRAC_W);
    endfunction

    function automatic logic signed [DATA_W-1:0] clip16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return DATA_W'(v);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
        case (idx)
            CFG_KP:            gain_p      = val;
            CFG_KI_TIMES_STEP: gain_i      = val;
            CFG_KD_OVER_STEP:  gain_d      = val;
            CFG_INITIAL_DRIVE: start_drive = val;
            CFG_GUARD_STEPS:   guard_ticks = val;
            CFG_MIN_OUTPUT:    out_lo      = val;
            CFG_MAX_OUTPUT:    out_hi      = val;
            default: ;
        endcase
    endfunction

    function automatic drive_word_t compute_drive(input logic signed [DATA_W-1:0] tgt,
                                                  input logic signed [DATA_W-1:0] meas,
                                                  input logic signed [DATA_W-1:0] spd);
        drive_word_t w;
        longint e, acc, u, hi, lo, floor_q;
        w.startup = 1'b0;
        if (tick_ctr == '0) begin
            w.drive   = start_drive;
            w.startup = 1'b1;
            tick_ctr  = 1;
        end
        else if (tick_ctr == 1 && spd < 2) begin
            // stalled on the second tick: hold the start-up drive
            w.drive   = start_drive;
            w.startup = 1'b1;
        end
        else begin
            e   = longint'(tgt) - longint'(meas);
            acc = longint'(integ_acc) + e;
            if (acc > ACC_MAX) begin
                acc        = ACC_MAX;
                acc_hit_hi = 1'b1;
            end
            if (acc < ACC_MIN) begin
                acc        = ACC_MIN;
                acc_hit_lo = 1'b1;
            end
            integ_acc = SUM_W'(acc);
            // all terms in Q.10; 0.75*target - measured is (3t - 4m)/4
            u = longint'(gain_p) * (3 * longint'(tgt) - 4 * longint'(meas))
              + longint'(gain_i) * longint'(integ_acc) * 4
              + longint'(gain_d) * (longint'(spd) - longint'(last_speed)) * 4;
            last_speed = spd;
            hold_err   = ERR_W'(e);
            floor_q    = longint'(start_drive) * 1024;
            if (tick_ctr < guard_ticks && u < floor_q)
                u = floor_q;
            hold_raw = clip16(round_half_away(u));
            hi = longint'(out_hi) * 1024;
            lo = longint'(out_lo) * 1024;
            // upper bound wins when the range is inverted
            if (u > hi)
                u = hi;
            else if (u < lo)
                u = lo;
            w.drive = DATA_W'(round_half_away(u));
            if (tick_ctr != '1)
                tick_ctr = tick_ctr + 1'b1;
            else
                ctr_held = 1'b1;
        end
        w.raw = hold_raw;
        w.err = hold_err;
        return w;
    endfunction

    function automatic drive_word_t word(input logic signed [DATA_W-1:0] d,
                                         input logic signed [DATA_W-1:0] r,
                                         input logic signed [ERR_W-1:0]  e,
                                         input logic s);
        drive_word_t w;
        w.drive   = d;
        w.raw     = r;
        w.err     = e;
        w.startup = s;
        return w;
    endfunction

    function automatic void row_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
        stim_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.val      = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_tick(input logic signed [DATA_W-1:0] t,
                                     input logic signed [DATA_W-1:0] m,
                                     input logic signed [DATA_W-1:0] s,
                                     input bit typed, input drive_word_t want);
        stim_row_t r;
        r       = '{default: '0};
        r.tgt   = t;
        r.meas  = m;
        r.spd   = s;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            5:       return DATA_W'($urandom);
            default: return DATA_W'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            5:       return DATA_W'($urandom);
            default: return DATA_W'(int'($urandom_range(0, 6000)) - 3000);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_edge();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'd1;
            4:       return 16'd2;
            default: return '0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("word %0d: %s got %0d, expected %0d", words_seen, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
        reg_writes++;
    endtask

    // stop offering, let every drive word come out, then let the pipe run idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic send_tick(input logic signed [DATA_W-1:0] t,
                             input logic signed [DATA_W-1:0] m,
                             input logic signed [DATA_W-1:0] s,
                             input bit typed, input drive_word_t want);
        drive_word_t w;
        if (cfg_wr_en)
            cfg_wr_en <= 1'b0;
        // each idle cycle drawn on its own
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {s, m, t};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        w = compute_drive(t, m, s);
        pending_drive.push_back(typed ? want : w);
        ticks_sent++;
    endtask

    task automatic random_tick();
        logic signed [DATA_W-1:0] t, m, s;
        case ($urandom_range(0, 3))
            0: begin
                t = DATA_W'($urandom);
                m = DATA_W'($urandom);
                s = DATA_W'($urandom);
            end
            1: begin
                t = DATA_W'(int'($urandom_range(0, 600)) - 300);
                m = DATA_W'(int'($urandom_range(0, 600)) - 300);
                s = DATA_W'(int'($urandom_range(0, 20)) - 10);
            end
            2: begin
                t = pick_edge();
                m = pick_edge();
                s = pick_edge();
            end
            default: begin
                // measured tracking the target, speed drifting slowly
                t = DATA_W'($urandom);
                m = t + DATA_W'(int'($urandom_range(0, 200)) - 100);
                s = last_speed + DATA_W'(int'($urandom_range(0, 40)) - 20);
            end
        endcase
        send_tick(t, m, s, 1'b0, '0);
    endtask

    task automatic random_settings(input bit pin_guard);
        logic signed [DATA_W-1:0] lo, hi;
        logic [DATA_W-1:0]        guard;
        settle();
        write_reg(CFG_KP, pick_gain());
        write_reg(CFG_KI_TIMES_STEP, pick_gain());
        write_reg(CFG_KD_OVER_STEP, pick_gain());
        write_reg(CFG_INITIAL_DRIVE, pick_level());
        case ($urandom_range(0, 3))
            0: begin
                lo = 16'sh8000;
                hi = 16'sh7FFF;
            end
            1: begin
                lo = pick_level();
                hi = lo + DATA_W'($urandom_range(0, 6000));
            end
            2: begin
                lo = DATA_W'($urandom_range(0, 3000));
                hi = DATA_W'(-int'($urandom_range(0, 3000)));
            end
            default: begin
                lo = DATA_W'($urandom);
                hi = DATA_W'($urandom);
            end
        endcase
        case ($urandom_range(0, 3))
            0:       guard = '0;
            1:       guard = '1;
            2:       guard = tick_ctr + DATA_W'($urandom_range(0, 400));
            default: guard = DATA_W'($urandom);
        endcase
        if (pin_guard)
            guard = '1;
        write_reg(CFG_MIN_OUTPUT, lo);
        write_reg(CFG_MAX_OUTPUT, hi);
        write_reg(CFG_GUARD_STEPS, guard);
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_SPARE, DATA_W'($urandom));
    endtask

    // receiver: random idling, or a long hold-off when one is requested
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_req != 0) begin
                stall_left = stall_req;
                stall_req  = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_words
        drive_word_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got.drive   = m_tdata[15:0];
            got.raw     = m_tdata[31:16];
            got.err     = m_tdata[48:32];
            got.startup = m_tuser;
            if (pending_drive.size() == 0)
                flag_mismatch("drive word with nothing pending, drive", got.drive, 0);
            else begin
                want = pending_drive.pop_front();
                if (got.drive !== want.drive)
                    flag_mismatch("drive", got.drive, want.drive);
                if (got.raw !== want.raw)
                    flag_mismatch("raw_drive", got.raw, want.raw);
                if (got.err !== want.err)
                    flag_mismatch("loop_error", got.err, want.err);
                if (got.startup !== want.startup)
                    flag_mismatch("in_startup", got.startup, want.startup);
            end
            words_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d drive words pending",
                     WATCHDOG_LIMIT, pending_drive.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;

        gain_p      = '0;
        gain_i      = '0;
        gain_d      = '0;
        start_drive = '0;
        guard_ticks = '0;
        out_lo      = 16'sh8000;
        out_hi      = 16'sh7FFF;
        tick_ctr    = '0;
        integ_acc   = '0;
        last_speed  = '0;
        hold_raw    = '0;
        hold_err    = '0;

        // start-up ticks, zero gains, then rounding, extremes, inverted range, guard floor
        row_write(CFG_INITIAL_DRIVE, 16'h7FFF);
        row_write(CFG_MIN_OUTPUT, 16'(-100));
        row_write(CFG_MAX_OUTPUT, 16'd100);
        row_write(CFG_SPARE, 16'h1234);
        row_tick(100, 50, 1000, 1'b1, word(32767, 0, 0, 1'b1));
        row_tick(5, 3, 1, 1'b1, word(32767, 0, 0, 1'b1));
        row_tick(7, 7, -32768, 1'b1, word(32767, 0, 0, 1'b1));
        row_tick(32767, -32768, 2, 1'b1, word(0, 0, 65535, 1'b0));
        row_tick(-32768, 32767, 32767, 1'b1, word(0, 0, -65535, 1'b0));
        row_write(CFG_KP, 16'h0100);
        row_write(CFG_INITIAL_DRIVE, 16'h0000);
        row_write(CFG_MIN_OUTPUT, 16'h8000);
        row_write(CFG_MAX_OUTPUT, 16'h7FFF);
        row_tick(4, 0, 0, 1'b1, word(3, 3, 4, 1'b0));
        row_write(CFG_KP, 16'h0080);
        row_tick(4, 2, 0, 1'b0, '0);
        row_tick(-4, -2, 0, 1'b0, '0);
        row_write(CFG_KP, 16'h7FFF);
        row_write(CFG_KI_TIMES_STEP, 16'h7FFF);
        row_write(CFG_KD_OVER_STEP, 16'h7FFF);
        row_tick(32767, -32768, 32767, 1'b0, '0);
        row_tick(-32768, 32767, -32768, 1'b0, '0);
        row_write(CFG_KP, 16'h8000);
        row_write(CFG_KI_TIMES_STEP, 16'h8000);
        row_write(CFG_KD_OVER_STEP, 16'h8000);
        row_tick(32767, -32768, -32768, 1'b0, '0);
        row_tick(-32768, 32767, 32767, 1'b0, '0);
        row_write(CFG_KP, 16'h0100);
        row_write(CFG_KI_TIMES_STEP, 16'h0000);
        row_write(CFG_KD_OVER_STEP, 16'h0000);
        row_write(CFG_MIN_OUTPUT, 16'd100);
        row_write(CFG_MAX_OUTPUT, 16'(-100));
        row_tick(0, 0, 0, 1'b0, '0);
        row_tick(0, 200, 0, 1'b0, '0);
        row_tick(0, 100, 0, 1'b0, '0);
        row_write(CFG_MIN_OUTPUT, 16'h8000);
        row_write(CFG_MAX_OUTPUT, 16'h7FFF);
        row_write(CFG_GUARD_STEPS, 16'hFFFF);
        row_write(CFG_INITIAL_DRIVE, 16'd500);
        row_tick(0, 1000, 0, 1'b0, '0);
        row_tick(10000, 0, 0, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.is_write) begin
                if (i == 0 || !directed_rows[i - 1].is_write)
                    settle();
                write_reg(r.idx, r.val);
            end
            else
                send_tick(r.tgt, r.meas, r.spd, r.typed, r.want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_settings(1'b0);
            calm = (ph == 5);
            for (int n = 0; n < RANDOM_TICKS / RANDOM_PHASES; n++) begin
                if (ph == 1 && n == 40)
                    stall_req = HOLD_OFF;
                random_tick();
            end
        end
        calm = 1'b0;

        settle();
        repeat (LATENCY) @(posedge clk);
        $display("Covered %0d ticks and %0d drive words over %0d register writes, %0d mismatches.",
                 ticks_sent, words_seen, reg_writes, mismatches);
        $display("Tick counter held at top: %0s; error sum pinned high: %0s, low: %0s.",
                 ctr_held ? "yes" : "no", acc_hit_hi ? "yes" : "no", acc_hit_lo ? "yes" : "no");
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
